/* rtl/rc_discharge_sensor_array_reader_defines.svh */
`ifndef RC_DISCHARGE_SENSOR_ARRAY_READER_DEFINES_SVH
`define RC_DISCHARGE_SENSOR_ARRAY_READER_DEFINES_SVH

// same-cycle implication
`define RCDSAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rcdsar check failed");

// next-cycle implication
`define RCDSAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rcdsar check failed");

`endif

/* rtl/rcdsar_pkg.sv */
`default_nettype none
package rcdsar_pkg;

	localparam int SENSOR_COUNT = 8;
	localparam int NSENS = (SENSOR_COUNT > 8) ? 8 : ((SENSOR_COUNT < 1) ? 1 : SENSOR_COUNT);
	localparam int IDX_W = (NSENS > 1) ? $clog2(NSENS) : 1;

	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_SETTLE_ON  = 3'd1;
	localparam logic [2:0] PH_CHARGE     = 3'd2;
	localparam logic [2:0] PH_CAPTURE    = 3'd3;
	localparam logic [2:0] PH_SETTLE_OFF = 3'd4;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	localparam logic [1:0] EM_OFF  = 2'd0;
	localparam logic [1:0] EM_ON   = 2'd1;
	localparam logic [1:0] EM_READ = 2'd2;

	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_READING = 1'b1;

	localparam logic [2:0] CFG_MAX_VALUE      = 3'd0;
	localparam logic [2:0] CFG_CUT_VALUE      = 3'd1;
	localparam logic [2:0] CFG_CHARGE_TICKS   = 3'd2;
	localparam logic [2:0] CFG_SETTLE_TICKS   = 3'd3;
	localparam logic [2:0] CFG_EMITTER_FITTED = 3'd4;
	localparam logic [2:0] CFG_EMITTER_HIGH   = 3'd5;

	typedef struct packed {
		logic       step;
		logic       load_reading;
		logic       load_status;
		logic [2:0] idx;
	} rcdsar_cmd_t;

	typedef struct packed {
		logic capture_end;
	} rcdsar_stat_t;

endpackage
`default_nettype wire

/* rtl/rcdsar_in_if.sv */
`default_nettype none
interface rcdsar_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [1:0] emitter_mode;
	logic [7:0] pin_levels;

	modport source (output valid, output mode, output emitter_mode, output pin_levels,
		input ready);
	modport sink (input valid, input mode, input emitter_mode, input pin_levels,
		output ready);
endinterface
`default_nettype wire

/* rtl/rcdsar_out_if.sv */
`default_nettype none
interface rcdsar_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic        busy_res;
	logic        charge_drive;
	logic        emitter_pin;
	logic [2:0]  sensor_index;
	logic [15:0] sensor_value;
	logic        object_present;
	logic        previous_present;
	logic        last;

	modport source (output valid, output kind, output busy_res, output charge_drive,
		output emitter_pin, output sensor_index, output sensor_value,
		output object_present, output previous_present, output last, input ready);
	modport sink (input valid, input kind, input busy_res, input charge_drive,
		input emitter_pin, input sensor_index, input sensor_value,
		input object_present, input previous_present, input last, output ready);
endinterface
`default_nettype wire

/* rtl/rc_discharge_sensor_array_reader.sv */
// RC-discharge reflectance sensor array reader.
// req carries start items (mode 0, with emitter_mode) and 1 us tick items
// (mode 1, with the sampled pin levels). res carries the results of each item:
// a tick that ends the capture gives one reading per sensor (index 0 first)
// followed by a status; every other item gives only a status. The status, with
// last set, is always the final result of an item.
// Results are registered: an accepted item moves the sequencer state to the
// readout or status step, which loads the output register; results then follow
// one per cycle while res is ready. req is taken again once the status is in the
// output register, so a new item can enter while the status still waits to be
// taken. When res stalls, the output register holds its item and the readout
// waits. Configuration is written through wr_en / wr_index / wr_data; the user
// must write it only while idle, which the block itself does not enforce. Reset
// puts the configuration registers at their defaults, the sequence idle with the
// emitter off, and clears the presence bits; res shows nothing until an item.
`default_nettype none
module rc_discharge_sensor_array_reader
	import rcdsar_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [15:0] wr_data,
	rcdsar_in_if.sink        req,
	rcdsar_out_if.source     res
);

	rcdsar_cmd_t  cmd;
	rcdsar_stat_t stat;

	rcdsar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rcdsar_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.mode             (req.mode),
		.emitter_mode     (req.emitter_mode),
		.pin_levels       (req.pin_levels),
		.cmd              (cmd),
		.stat             (stat),
		.kind             (res.kind),
		.busy_res         (res.busy_res),
		.charge_drive     (res.charge_drive),
		.emitter_pin      (res.emitter_pin),
		.sensor_index     (res.sensor_index),
		.sensor_value     (res.sensor_value),
		.object_present   (res.object_present),
		.previous_present (res.previous_present),
		.last             (res.last)
	);

endmodule
`default_nettype wire

/* rtl/rcdsar_ctrl.sv */
`default_nettype none
module rcdsar_ctrl
	import rcdsar_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_ready,
	output logic              res_valid,
	input  wire logic         res_ready,
	input  wire rcdsar_stat_t stat,
	output rcdsar_cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_STAT = 2'd2;

	logic [1:0] state_q, state_d;
	logic [2:0] idx_q, idx_d;
	logic       ov_q;
	logic       accept;
	logic       slot_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !ov_q || res_ready;
	assign res_valid = ov_q;

	always_comb begin
		cmd.step         = accept;
		cmd.load_reading = (state_q == ST_READ) && slot_free;
		cmd.load_status  = (state_q == ST_STAT) && slot_free;
		cmd.idx          = idx_q;
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_d   = 3'd0;
					state_d = stat.capture_end ? ST_READ : ST_STAT;
				end
			end
			ST_READ: begin
				if (slot_free) begin
					if (idx_q == 3'(NSENS - 1)) begin
						state_d = ST_STAT;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			ST_STAT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 3'd0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.load_reading || cmd.load_status) begin
				ov_q <= 1'b1;
			end else if (res_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/rcdsar_datapath.sv */
`default_nettype none
module rcdsar_datapath
	import rcdsar_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [2:0]   wr_index,
	input  wire logic [15:0]  wr_data,
	input  wire logic         mode,
	input  wire logic [1:0]   emitter_mode,
	input  wire logic [7:0]   pin_levels,
	input  wire rcdsar_cmd_t  cmd,
	output rcdsar_stat_t      stat,
	output logic              kind,
	output logic              busy_res,
	output logic              charge_drive,
	output logic              emitter_pin,
	output logic [2:0]        sensor_index,
	output logic [15:0]       sensor_value,
	output logic              object_present,
	output logic              previous_present,
	output logic              last
);

	// configuration
	logic [15:0] max_value_q;
	logic [15:0] cut_value_q;
	logic [7:0]  charge_ticks_q;
	logic [9:0]  settle_ticks_q;
	logic        fitted_q;
	logic        active_high_q;

	// sequence state
	logic [2:0]  phase_q, phase_d;
	logic [9:0]  count_q, count_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [1:0]  em_q, em_d;
	logic        lit_q, lit_d;
	logic [7:0]  pres_q, pres_d;
	logic [7:0]  prev_q, prev_d;
	logic [15:0] cap_q [NSENS];
	logic [15:0] cap_d [NSENS];

	logic [9:0]  count_inc;
	logic [15:0] elapsed_inc;
	logic        settle_on;
	logic        pin_now;
	logic [15:0] rd_value;
	logic        rd_pres;

	// output register
	logic        kind_q, busy_q, charge_q, pin_q, opres_q, oprev_q, last_q;
	logic [2:0]  sidx_q;
	logic [15:0] sval_q;

	assign count_inc   = count_q + 10'd1;
	assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
	assign settle_on   = fitted_q && (settle_ticks_q != 10'd0);
	assign pin_now     = fitted_q && (lit_q ? active_high_q : !active_high_q);

	assign stat.capture_end = (mode == MODE_TICK) && (phase_q == PH_CAPTURE)
		&& (elapsed_inc >= max_value_q);

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		elapsed_d = elapsed_q;
		em_d      = em_q;
		lit_d     = lit_q;
		pres_d    = pres_q;
		prev_d    = prev_q;
		for (int i = 0; i < NSENS; i++) begin
			cap_d[i] = cap_q[i];
		end
		if (cmd.step) begin
			if (mode == MODE_START) begin
				if (phase_q == PH_IDLE) begin
					em_d   = emitter_mode;
					lit_d  = (emitter_mode == EM_ON) || (emitter_mode == EM_READ);
					prev_d = pres_q;
					pres_d = 8'd0;
					for (int i = 0; i < NSENS; i++) begin
						cap_d[i] = max_value_q;
					end
					count_d = 10'd0;
					if (settle_on) begin
						phase_d = PH_SETTLE_ON;
					end else if (charge_ticks_q == 8'd0) begin
						phase_d   = PH_CAPTURE;
						elapsed_d = 16'd0;
					end else begin
						phase_d = PH_CHARGE;
					end
				end
			end else begin
				case (phase_q)
					PH_SETTLE_ON: begin
						count_d = count_inc;
						if (count_inc >= settle_ticks_q) begin
							count_d = 10'd0;
							if (charge_ticks_q == 8'd0) begin
								phase_d   = PH_CAPTURE;
								elapsed_d = 16'd0;
							end else begin
								phase_d = PH_CHARGE;
							end
						end
					end
					PH_CHARGE: begin
						count_d = count_inc;
						if (count_inc >= {2'b00, charge_ticks_q}) begin
							phase_d   = PH_CAPTURE;
							elapsed_d = 16'd0;
						end
					end
					PH_CAPTURE: begin
						for (int i = 0; i < NSENS; i++) begin
							if (!pin_levels[i] && (elapsed_q < cap_q[i])) begin
								cap_d[i] = elapsed_q;
							end
						end
						elapsed_d = elapsed_inc;
						if (stat.capture_end) begin
							phase_d = PH_IDLE;
							if (em_q == EM_READ) begin
								lit_d = 1'b0;
								if (settle_on) begin
									phase_d = PH_SETTLE_OFF;
									count_d = 10'd0;
								end
							end
						end
					end
					PH_SETTLE_OFF: begin
						count_d = count_inc;
						if (count_inc >= settle_ticks_q) begin
							phase_d = PH_IDLE;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
		if (cmd.load_reading) begin
			pres_d[cmd.idx] = rd_pres;
		end
	end

	assign rd_value = cap_q[cmd.idx[IDX_W-1:0]];
	assign rd_pres  = (rd_value < max_value_q) && (rd_value < cut_value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q    <= 16'd3000;
			cut_value_q    <= 16'd1000;
			charge_ticks_q <= 8'd10;
			settle_ticks_q <= 10'd200;
			fitted_q       <= 1'b1;
			active_high_q  <= 1'b1;
			phase_q        <= PH_IDLE;
			count_q        <= 10'd0;
			elapsed_q      <= 16'd0;
			em_q           <= EM_OFF;
			lit_q          <= 1'b0;
			pres_q         <= 8'd0;
			prev_q         <= 8'd0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_MAX_VALUE:      max_value_q    <= wr_data;
					CFG_CUT_VALUE:      cut_value_q    <= wr_data;
					CFG_CHARGE_TICKS:   charge_ticks_q <= wr_data[7:0];
					CFG_SETTLE_TICKS:   settle_ticks_q <= wr_data[9:0];
					CFG_EMITTER_FITTED: fitted_q       <= wr_data[0];
					CFG_EMITTER_HIGH:   active_high_q  <= wr_data[0];
					default: ;
				endcase
			end
			phase_q   <= phase_d;
			count_q   <= count_d;
			elapsed_q <= elapsed_d;
			em_q      <= em_d;
			lit_q     <= lit_d;
			pres_q    <= pres_d;
			prev_q    <= prev_d;
		end
	end

	// capture lanes, written at every start before any readout
	always_ff @(posedge clk) begin
		for (int i = 0; i < NSENS; i++) begin
			cap_q[i] <= cap_d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_reading || cmd.load_status) begin
			busy_q   <= (phase_q != PH_IDLE);
			charge_q <= (phase_q == PH_CHARGE);
			pin_q    <= pin_now;
			if (cmd.load_reading) begin
				kind_q  <= KIND_READING;
				sidx_q  <= cmd.idx;
				sval_q  <= rd_value;
				opres_q <= rd_pres;
				oprev_q <= prev_q[cmd.idx];
				last_q  <= 1'b0;
			end else begin
				kind_q  <= KIND_STATUS;
				sidx_q  <= 3'd0;
				sval_q  <= 16'd0;
				opres_q <= 1'b0;
				oprev_q <= 1'b0;
				last_q  <= 1'b1;
			end
		end
	end

	assign kind             = kind_q;
	assign busy_res         = busy_q;
	assign charge_drive     = charge_q;
	assign emitter_pin      = pin_q;
	assign sensor_index     = sidx_q;
	assign sensor_value     = sval_q;
	assign object_present   = opres_q;
	assign previous_present = oprev_q;
	assign last             = last_q;

endmodule
`default_nettype wire

/* rtl/rcdsar_checker.sv */
`default_nettype none
`include "rc_discharge_sensor_array_reader_defines.svh"
module rcdsar_checker
	import rcdsar_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic res_kind,
	input wire logic res_busy,
	input wire logic res_charge,
	input wire logic res_last
);

	`RCDSAR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`RCDSAR_ASSERT_IMP(a_reading_not_last, clk, arst_n,
		res_valid && (res_kind == KIND_READING), !res_last)
	`RCDSAR_ASSERT_IMP(a_charge_busy, clk, arst_n, res_valid && res_charge, res_busy)
	`RCDSAR_ASSERT_IMP(a_no_take_in_readout, clk, arst_n,
		res_valid && (res_kind == KIND_READING), !req_ready)

endmodule

bind rc_discharge_sensor_array_reader rcdsar_checker u_rcdsar_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_kind   (res.kind),
	.res_busy   (res.busy_res),
	.res_charge (res.charge_drive),
	.res_last   (res.last)
);
`default_nettype wire

/* test/tb_rc_discharge_sensor_array_reader.sv */
`timescale 1ns / 1ps
module tb_rc_discharge_sensor_array_reader;
	import rcdsar_pkg::*;

	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         HOLD_CYCLES = 80;
	localparam logic [1:0] EM_UNUSED   = 2'd3;
	localparam int         PINS_RANDOM = 0;
	localparam int         PINS_HIGH   = 1;
	localparam int         PINS_LOW    = 2;

	typedef struct packed {
		logic       mode;
		logic [1:0] em;
		logic [7:0] pins;
	} sensor_item_t;

	typedef struct packed {
		logic        kind;
		logic        busy;
		logic        charge;
		logic        pin;
		logic [2:0]  idx;
		logic [15:0] val;
		logic        pres;
		logic        prev;
		logic        last;
	} reading_t;

	typedef struct packed {
		logic [2:0]       phase;
		logic [9:0]       count;
		logic [15:0]      elapsed;
		logic [1:0]       em;
		logic             lit;
		logic [7:0][15:0] cap;
		logic [7:0]       pres;
		logic [7:0]       prev;
	} reader_state_t;

	typedef struct packed {
		logic [15:0] max_v;
		logic [15:0] cut_v;
		logic [7:0]  charge;
		logic [9:0]  settle;
		logic        fitted;
		logic        act_high;
	} reader_cfg_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = CFG_MAX_VALUE;
	logic [15:0] wr_data = '0;

	rcdsar_in_if  req ();
	rcdsar_out_if res ();

	rc_discharge_sensor_array_reader u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req.sink),
		.res      (res.source)
	);

	reader_cfg_t   cfg;
	reader_state_t plan_state;
	reader_state_t model_state;
	reading_t      due_results[$];
	sensor_item_t  pending_items[$];
	sensor_item_t  next_item;
	sensor_item_t  taken_item;
	reading_t      want;

	int  n_sent = 0;
	int  n_taken = 0;
	int  n_useful = 0;
	int  n_results = 0;
	int  n_readings = 0;
	int  cycles = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  req_taken = 0;
	bit  hold_req = 0;
	bit  quiet = 0;
	bit  press = 0;
	bit  failed = 0;

	function automatic reading_t result_of(input reader_state_t s, input logic kind,
		input logic [2:0] idx, input logic [15:0] val, input logic pres, input logic prev,
		input logic last);
		reading_t r;
		r.kind   = kind;
		r.busy   = (s.phase != PH_IDLE);
		r.charge = (s.phase == PH_CHARGE);
		r.pin    = cfg.fitted ? (s.lit ? cfg.act_high : !cfg.act_high) : 1'b0;
		r.idx    = idx;
		r.val    = val;
		r.pres   = pres;
		r.prev   = prev;
		r.last   = last;
		return r;
	endfunction

	function automatic void begin_charge(inout reader_state_t s);
		s.count = '0;
		if (cfg.charge == 0) begin
			s.phase   = PH_CAPTURE;
			s.elapsed = '0;
		end else begin
			s.phase = PH_CHARGE;
		end
	endfunction

	function automatic void read_step(inout reader_state_t s, input sensor_item_t it,
		input bit record);
		logic [15:0] t;
		if (it.mode == MODE_START) begin
			if (s.phase == PH_IDLE) begin
				s.em   = it.em;
				s.lit  = (it.em == EM_ON || it.em == EM_READ);
				s.prev = s.pres;
				s.pres = '0;
				for (int i = 0; i < NSENS; i++)
					s.cap[i] = cfg.max_v;
				if (cfg.fitted && cfg.settle != 0) begin
					s.phase = PH_SETTLE_ON;
					s.count = '0;
				end else begin
					begin_charge(s);
				end
			end
		end else begin
			case (s.phase)
				PH_SETTLE_ON: begin
					s.count = s.count + 10'd1;
					if (s.count >= cfg.settle)
						begin_charge(s);
				end
				PH_CHARGE: begin
					s.count = s.count + 10'd1;
					if (s.count >= cfg.charge) begin
						s.phase   = PH_CAPTURE;
						s.elapsed = '0;
					end
				end
				PH_CAPTURE: begin
					t = s.elapsed;
					for (int i = 0; i < NSENS; i++)
						if (!it.pins[i] && t < s.cap[i])
							s.cap[i] = t;
					s.elapsed = (t < 16'hFFFF) ? t + 16'd1 : 16'hFFFF;
					if (s.elapsed >= cfg.max_v) begin
						for (int i = 0; i < NSENS; i++)
							if (s.cap[i] < cfg.max_v && s.cap[i] < cfg.cut_v)
								s.pres[i] = 1'b1;
						if (s.em == EM_READ) begin
							s.lit = 1'b0;
							if (cfg.fitted && cfg.settle != 0) begin
								s.phase = PH_SETTLE_OFF;
								s.count = '0;
							end else begin
								s.phase = PH_IDLE;
							end
						end else begin
							s.phase = PH_IDLE;
						end
						if (record)
							for (int i = 0; i < NSENS; i++)
								due_results.push_back(result_of(s, KIND_READING, 3'(i),
									s.cap[i], s.pres[i], s.prev[i], 1'b0));
					end
				end
				PH_SETTLE_OFF: begin
					s.count = s.count + 10'd1;
					if (s.count >= cfg.settle)
						s.phase = PH_IDLE;
				end
				default: begin
					s.phase = PH_IDLE;
				end
			endcase
		end
		if (record)
			due_results.push_back(result_of(s, KIND_STATUS, '0, '0, 1'b0, 1'b0, 1'b1));
	endfunction

	task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
		if (e !== a) begin
			failed = 1;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
		end
	endtask

	task automatic push_item(input logic mode, input logic [1:0] em, input logic [7:0] pins);
		sensor_item_t it;
		it.mode = mode;
		it.em   = em;
		it.pins = pins;
		if ((mode == MODE_START) == (plan_state.phase == PH_IDLE))
			n_useful++;
		read_step(plan_state, it, 1'b0);
		pending_items.push_back(it);
		n_sent++;
	endtask

	// one start (plus extra random starts when noisy), then ticks until the sequence is back to idle
	task automatic plan_read(input logic [1:0] em, input int style, input bit noisy);
		logic [7:0] pins;
		push_item(MODE_START, em, 8'($urandom));
		if (noisy)
			push_item(MODE_START, 2'($urandom), 8'($urandom));
		while (plan_state.phase != PH_IDLE) begin
			if (noisy && $urandom_range(0, 7) == 0)
				push_item(MODE_START, 2'($urandom), 8'($urandom));
			case (style)
				PINS_HIGH: pins = 8'hFF;
				PINS_LOW:  pins = 8'h00;
				default:   pins = 8'($urandom | $urandom);
			endcase
			push_item(MODE_TICK, 2'($urandom), pins);
		end
	endtask

	task automatic write_config(input logic [15:0] max_v, input logic [15:0] cut_v,
		input logic [7:0] charge, input logic [9:0] settle, input logic fitted,
		input logic act_high);
		cfg.max_v    = max_v;
		cfg.cut_v    = cut_v;
		cfg.charge   = charge;
		cfg.settle   = settle;
		cfg.fitted   = fitted;
		cfg.act_high = act_high;
		for (int r = 0; r < 6; r++) begin
			@(negedge clk);
			wr_en <= 1'b1;
			case (r)
				0: begin wr_index <= CFG_MAX_VALUE;      wr_data <= max_v; end
				1: begin wr_index <= CFG_CUT_VALUE;      wr_data <= cut_v; end
				2: begin wr_index <= CFG_CHARGE_TICKS;   wr_data <= {8'd0, charge}; end
				3: begin wr_index <= CFG_SETTLE_TICKS;   wr_data <= {6'd0, settle}; end
				4: begin wr_index <= CFG_EMITTER_FITTED; wr_data <= {15'd0, fitted}; end
				default: begin
					wr_index <= CFG_EMITTER_HIGH;
					wr_data  <= {15'd0, act_high};
				end
			endcase
		end
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain;
		while (!(n_taken == n_sent && due_results.size() == 0))
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	initial begin
		clk              = 1'b0;
		req.valid        = 1'b0;
		req.mode         = MODE_START;
		req.emitter_mode = EM_OFF;
		req.pin_levels   = 8'hFF;
		res.ready        = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_taken) begin
			req_taken = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
				req.valid <= 1'b0;
			end else if (pending_items.size() != 0 && !quiet && !press
				&& $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 2);
				req.valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				req.valid        <= 1'b1;
				req.mode         <= next_item.mode;
				req.emitter_mode <= next_item.em;
				req.pin_levels   <= next_item.pins;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			n_results++;
			if (due_results.size() == 0) begin
				failed = 1;
				$display("%0t: result with nothing expected, expected none, got kind %0d value %0d",
					$time, res.kind, res.sensor_value);
			end else begin
				want = due_results.pop_front();
				if (want.kind == KIND_READING)
					n_readings++;
				check_field("kind", 16'(want.kind), 16'(res.kind));
				check_field("busy_res", 16'(want.busy), 16'(res.busy_res));
				check_field("charge_drive", 16'(want.charge), 16'(res.charge_drive));
				check_field("emitter_pin", 16'(want.pin), 16'(res.emitter_pin));
				check_field("sensor_index", 16'(want.idx), 16'(res.sensor_index));
				check_field("sensor_value", want.val, res.sensor_value);
				check_field("object_present", 16'(want.pres), 16'(res.object_present));
				check_field("previous_present", 16'(want.prev), 16'(res.previous_present));
				check_field("last", 16'(want.last), 16'(res.last));
			end
		end
		if (arst_n && req.valid && req.ready) begin
			taken_item.mode = req.mode;
			taken_item.em   = req.emitter_mode;
			taken_item.pins = req.pin_levels;
			read_step(model_state, taken_item, 1'b1);
			n_taken++;
			req_taken = 1'b1;
		end
	end

	initial begin
		int rand_items;
		int k;
		int mark;
		rand_items = 0;
		k          = 0;
		cfg        = '{max_v: 16'd3000, cut_v: 16'd1000, charge: 8'd10, settle: 10'd200,
			fitted: 1'b1, act_high: 1'b1};
		plan_state  = '0;
		model_state = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ticks while idle at the reset settings
		push_item(MODE_TICK, EM_OFF, 8'hFF);
		push_item(MODE_TICK, EM_UNUSED, 8'h00);
		drain();

		write_config(16'd4, 16'd2, 8'd1, 10'd1, 1'b1, 1'b1);
		plan_read(EM_ON, PINS_LOW, 1'b1);
		plan_read(EM_READ, PINS_HIGH, 1'b0);
		plan_read(EM_OFF, PINS_RANDOM, 1'b0);
		plan_read(EM_UNUSED, PINS_LOW, 1'b0);
		drain();

		// zero capture length, no charge, no emitter
		write_config(16'd0, 16'd0, 8'd0, 10'd0, 1'b0, 1'b0);
		plan_read(EM_READ, PINS_LOW, 1'b0);
		plan_read(EM_ON, PINS_RANDOM, 1'b1);
		drain();

		write_config(16'd1, 16'hFFFF, 8'd3, 10'd0, 1'b1, 1'b0);
		plan_read(EM_READ, PINS_LOW, 1'b0);
		drain();

		write_config(16'd3, 16'hFFFF, 8'd1, 10'd2, 1'b1, 1'b1);
		plan_read(EM_READ, PINS_RANDOM, 1'b0);
		drain();

		write_config(16'hFFFF, 16'd40000, 8'd8, 10'd512, 1'b0, 1'b1);
		push_item(MODE_TICK, EM_ON, 8'h5A);
		push_item(MODE_TICK, EM_READ, 8'hA5);
		drain();

		while (rand_items < 60) begin
			quiet = (rand_items >= 40);
			write_config(($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 10)),
				16'($urandom_range(0, 12)), 8'($urandom_range(0, 3)),
				10'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
			mark  = n_useful;
			press = (k == 2);
			while (n_useful - mark < 14) begin
				if ($urandom_range(0, 3) == 0)
					push_item(MODE_TICK, 2'($urandom), 8'($urandom));
				plan_read(2'($urandom), ($urandom_range(0, 4) == 0)
					? int'($urandom_range(PINS_HIGH, PINS_LOW)) : PINS_RANDOM,
					$urandom_range(0, 2) == 0);
			end
			if (press) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			drain();
			press      = 1'b0;
			rand_items = rand_items + (n_useful - mark);
			k++;
		end

		$display("%0d items driven over %0d settings, %0d results checked (%0d readings)",
			n_taken, k + 6, n_results, n_readings);
		$display("covered emitter modes, zero and full-scale registers and a long result stall");
		if (!failed)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
